/* rtl/uuid1_pkg.sv */
`default_nettype none

package uuid1_pkg;

    // field widths
    localparam int TIME_W  = 60;
    localparam int NODE_W  = 48;
    localparam int SEQ_W   = 16;
    localparam int TICK_W  = 16;
    localparam int HALF_W  = 64;

    // base below 2^60 plus a 16-bit counter needs one more bit
    localparam int STAMP_W = TIME_W + 1;

    // layout codes of a version 1 identifier
    localparam logic [3:0] UUID_VERSION = 4'h1;
    localparam logic [1:0] UUID_VARIANT = 2'b10;

    localparam logic [TICK_W-1:0] IDS_PER_TICK_RST = 16'd1024;
    localparam logic [TICK_W-1:0] TICK_MAX         = 16'hFFFF;

    typedef logic [STAMP_W-1:0] t_stamp;

endpackage

`default_nettype wire

/* rtl/uuid_v1_time_generator.sv */
// channel  direction  handshake                 payload
// in       sink       i_in_valid / o_in_stall   i_system_time, i_node_id, i_random_seq
// out      source     o_out_valid / i_out_stall o_uuid_high, o_uuid_low
// cfg      sink       i_cfg_wr_en               i_cfg_wr_data (ids_per_tick)
//
// one beat per cycle sustained while the output is not stalled
// the input register feeds the timestamp core, whose state advances once per beat
// that moves into the output register
// synchronous active-low reset; ids_per_tick returns to 1024, core state to zero
// a stalled output holds both stages; o_in_stall rises only when both are full
`default_nettype none

module uuid_v1_time_generator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         i_cfg_wr_en,
    input  wire logic [uuid1_pkg::TICK_W-1:0] i_cfg_wr_data,

    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [uuid1_pkg::TIME_W-1:0] i_system_time,
    input  wire logic [uuid1_pkg::NODE_W-1:0] i_node_id,
    input  wire logic [uuid1_pkg::SEQ_W-1:0]  i_random_seq,

    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [uuid1_pkg::HALF_W-1:0] o_uuid_high,
    output logic      [uuid1_pkg::HALF_W-1:0] o_uuid_low
);
    import uuid1_pkg::*;

    // configuration register
    logic [TICK_W-1:0] r_ids_per_tick;

    // input stage
    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_time;
    logic [NODE_W-1:0] r_in_node;
    logic [SEQ_W-1:0]  r_in_rnd;

    // output stage
    logic              r_out_valid;
    logic [HALF_W-1:0] r_uuid_high;
    logic [HALF_W-1:0] r_uuid_low;

    logic              out_free;
    logic              advance;
    logic              take_in;
    t_stamp            stamp;
    logic [SEQ_W-1:0]  seq;
    logic [HALF_W-1:0] n_uuid_high;
    logic [HALF_W-1:0] n_uuid_low;

    // output register empties or drains this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    // input-stage beat moves to the output register and steps the core
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign take_in    = i_in_valid && !o_in_stall;

    uuid1_stamp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ids_per_tick (r_ids_per_tick),
        .i_step         (advance),
        .i_time         (r_in_time),
        .i_node         (r_in_node),
        .i_rnd          (r_in_rnd),
        .o_stamp        (stamp),
        .o_seq          (seq)
    );

    // time low 32 | time mid 16 | version and time high 12
    assign n_uuid_high = {stamp[31:0], stamp[47:32], UUID_VERSION, stamp[59:48]};
    // variant | clock sequence low 14 | node
    assign n_uuid_low  = {UUID_VARIANT, seq[13:0], r_in_node};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids_per_tick <= IDS_PER_TICK_RST;
        end else if (i_cfg_wr_en) begin
            r_ids_per_tick <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_time <= i_system_time;
            r_in_node <= i_node_id;
            r_in_rnd  <= i_random_seq;
        end
        if (advance) begin
            r_uuid_high <= n_uuid_high;
            r_uuid_low  <= n_uuid_low;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_uuid_high = r_uuid_high;
    assign o_uuid_low  = r_uuid_low;

endmodule

`default_nettype wire

/* rtl/uuid1_stamp_core.sv */
`default_nettype none

module uuid1_stamp_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [uuid1_pkg::TICK_W-1:0] i_ids_per_tick,
    input  wire logic                         i_step,
    input  wire logic [uuid1_pkg::TIME_W-1:0] i_time,
    input  wire logic [uuid1_pkg::NODE_W-1:0] i_node,
    input  wire logic [uuid1_pkg::SEQ_W-1:0]  i_rnd,
    output uuid1_pkg::t_stamp                 o_stamp,
    output logic      [uuid1_pkg::SEQ_W-1:0]  o_seq
);
    import uuid1_pkg::*;

    logic              r_started;
    logic [TIME_W-1:0] r_base;
    logic [TICK_W-1:0] r_tick;
    t_stamp            r_stamp;
    logic [SEQ_W-1:0]  r_seq;
    logic [NODE_W-1:0] r_node;

    logic [TIME_W-1:0] n_base;
    logic [TICK_W-1:0] n_tick;
    t_stamp            n_stamp;
    logic [SEQ_W-1:0]  n_seq;

    logic   first;
    logic   below_limit;
    logic   newer;
    logic   rebase;
    logic   wrap;
    t_stamp now_ext;

    // r_stamp always equals r_base + r_tick, so the rebase test reduces to a compare on
    // r_stamp and the time-went-backwards test to a counter wrap check on r_tick
    always_comb begin
        now_ext     = {1'b0, i_time};
        first       = !r_started;
        below_limit = r_tick < i_ids_per_tick;
        newer       = now_ext > r_stamp;
        rebase      = !first && !below_limit && newer;
        wrap        = r_tick == TICK_MAX;

        n_base  = r_base;
        n_tick  = r_tick + TICK_W'(1);
        n_stamp = wrap ? {1'b0, r_base} : r_stamp + STAMP_W'(1);
        if (first) begin
            n_base  = i_time;
            n_tick  = TICK_W'(1);
            n_stamp = now_ext + STAMP_W'(1);
        end else if (rebase) begin
            n_base  = i_time;
            n_tick  = '0;
            n_stamp = now_ext;
        end

        // counter wrap is the only way the stamp can fall back
        n_seq = r_seq;
        if (first || (i_node != r_node)) begin
            n_seq = i_rnd;
        end else if (!rebase && wrap) begin
            n_seq = r_seq + SEQ_W'(1);
        end
    end

    assign o_stamp = n_stamp;
    assign o_seq   = n_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_base    <= '0;
            r_tick    <= '0;
            r_stamp   <= '0;
            r_seq     <= '0;
            r_node    <= '0;
        end else if (i_step) begin
            r_started <= 1'b1;
            r_base    <= n_base;
            r_tick    <= n_tick;
            r_stamp   <= n_stamp;
            r_seq     <= n_seq;
            r_node    <= i_node;
        end
    end

    a_stamp_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stamp == ({1'b0, r_base} + STAMP_W'(r_tick)))
        else $error("stamp out of step with base and counter");

    a_seq_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_seq) && $stable(r_stamp))
        else $error("state moved without a step");

    a_count_up : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_started && (r_tick < i_ids_per_tick)
            |=> r_tick == $past(r_tick) + TICK_W'(1))
        else $error("counter did not advance below the limit");

endmodule

`default_nettype wire

/* test/uuid_v1_time_generator_tb.sv */
`timescale 1ns / 1ps

module uuid_v1_time_generator_tb;

    import uuid1_pkg::*;

    // run guard, far above the slowest correct run
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned PHASE_BEATS  = 132;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam int unsigned DIR_COUNT    = 17;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [NODE_W-1:0] NODE_MAX = '1;
    localparam logic [SEQ_W-1:0]  SEQ_MAX  = '1;

    // one request beat, with an optional hand-typed answer
    typedef struct packed {
        logic [TIME_W-1:0] sys_time;
        logic [NODE_W-1:0] node;
        logic [SEQ_W-1:0]  seed;
        logic              typed;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
    } t_uuid_req;

    typedef struct packed {
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
    } t_uuid_pair;

    typedef enum logic {ROW_REQUEST, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [TICK_W-1:0] limit;
        t_uuid_req         req;
    } t_dir_row;

    // directed rows, walked in order right after reset (limit starts at 1024)
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        // first request latches the clock and seeds the clock sequence: stamp = base + 1
        '{ROW_REQUEST, 16'd0, '{60'd0, 48'd0, 16'd0, 1'b1,
            64'h0000_0001_0000_1000, 64'h8000_0000_0000_0000}},
        // all fields at their maximum, new node reseeds with all ones
        '{ROW_REQUEST, 16'd0, '{TIME_MAX, NODE_MAX, SEQ_MAX, 1'b1,
            64'h0000_0002_0000_1000, 64'hBFFF_FFFF_FFFF_FFFF}},
        // same node keeps its clock sequence
        '{ROW_REQUEST, 16'd0, '{60'd5, NODE_MAX, 16'h1234, 1'b0, 64'd0, 64'd0}},
        // limit of zero: every beat takes the rebase decision
        '{ROW_LIMIT, 16'd0, '{60'd0, 48'd0, 16'd0, 1'b0, 64'd0, 64'd0}},
        // older clock counts on
        '{ROW_REQUEST, 16'd0, '{60'd0, NODE_MAX, 16'd0, 1'b0, 64'd0, 64'd0}},
        // clock equal to base + counter does not rebase
        '{ROW_REQUEST, 16'd0, '{60'd4, NODE_MAX, 16'd0, 1'b0, 64'd0, 64'd0}},
        // newer clock rebases
        '{ROW_REQUEST, 16'd0, '{60'd100, NODE_MAX, 16'd0, 1'b0, 64'd0, 64'd0}},
        '{ROW_REQUEST, 16'd0, '{TIME_MAX, NODE_MAX, 16'd0, 1'b0, 64'd0, 64'd0}},
        // equal clock at the top: stamp reaches 2^60 and its low 60 bits drop to zero
        '{ROW_REQUEST, 16'd0, '{TIME_MAX, NODE_MAX, 16'd0, 1'b0, 64'd0, 64'd0}},
        '{ROW_REQUEST, 16'd0, '{60'd0, 48'd1, 16'h8001, 1'b0, 64'd0, 64'd0}},
        '{ROW_REQUEST, 16'd0, '{60'h555_5555_5555_5555, 48'hAAAA_AAAA_AAAA, 16'h5555,
            1'b0, 64'd0, 64'd0}},
        '{ROW_REQUEST, 16'd0, '{60'hAAA_AAAA_AAAA_AAAA, 48'h5555_5555_5555, 16'hAAAA,
            1'b0, 64'd0, 64'd0}},
        '{ROW_LIMIT, 16'd1, '{60'd0, 48'd0, 16'd0, 1'b0, 64'd0, 64'd0}},
        '{ROW_REQUEST, 16'd0, '{60'd200, 48'h5555_5555_5555, 16'd0, 1'b0, 64'd0, 64'd0}},
        '{ROW_REQUEST, 16'd0, '{60'd200, 48'h5555_5555_5555, 16'd7, 1'b0, 64'd0, 64'd0}},
        '{ROW_REQUEST, 16'd0, '{60'd210, 48'h5555_5555_5555, 16'd9, 1'b0, 64'd0, 64'd0}},
        '{ROW_REQUEST, 16'd0, '{60'h0F0, 48'h0000_FFFF_0000, 16'h00FF, 1'b0, 64'd0, 64'd0}}
    };

    // limits of the random phases, the last one back at the reset value
    localparam logic [TICK_W-1:0] PHASE_LIMITS [PHASE_COUNT] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'd16, 16'd40, IDS_PER_TICK_RST
    };

    // dut ports
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_wr_en    = 1'b0;
    logic [TICK_W-1:0] i_cfg_wr_data  = '0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic [TIME_W-1:0] i_system_time  = '0;
    logic [NODE_W-1:0] i_node_id      = '0;
    logic [SEQ_W-1:0]  i_random_seq   = '0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic [HALF_W-1:0] o_uuid_high;
    logic [HALF_W-1:0] o_uuid_low;

    // outputs sampled mid-cycle, so they are stable at the next rising edge
    logic              in_stall_s  = 1'b0;
    logic              out_valid_s = 1'b0;
    logic [HALF_W-1:0] high_s      = '0;
    logic [HALF_W-1:0] low_s       = '0;

    // generator state as the predictor sees it
    logic              gen_started    = 1'b0;
    logic [63:0]       gen_base       = '0;
    logic [TICK_W-1:0] gen_tick       = '0;
    logic [SEQ_W-1:0]  gen_clkseq     = '0;
    logic [63:0]       gen_last_stamp = '0;
    logic [NODE_W-1:0] gen_last_node  = '0;
    logic [TICK_W-1:0] gen_limit      = IDS_PER_TICK_RST;

    t_uuid_req   request_q [$];
    t_uuid_pair  uuid_due_q [$];
    t_uuid_req   cur_req;
    t_uuid_pair  predicted;
    t_uuid_pair  expected;

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned feed_gap    = 0;
    int unsigned feed_calm   = 0;
    int unsigned hold_len    = 0;
    int unsigned hold_calm   = 0;

    uuid_v1_time_generator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_system_time (i_system_time),
        .i_node_id     (i_node_id),
        .i_random_seq  (i_random_seq),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_uuid_high   (o_uuid_high),
        .o_uuid_low    (o_uuid_low)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // next identifier for one accepted request; advances the predictor state
    function automatic t_uuid_pair stamp_uuid(input logic [TIME_W-1:0] now,
                                              input logic [NODE_W-1:0] node,
                                              input logic [SEQ_W-1:0]  seed);
        logic        fresh;
        logic [63:0] stamp;
        t_uuid_pair  res;
        fresh = !gen_started;
        // first request latches the clock before the counter steps
        if (fresh) begin
            gen_base    = {4'b0, now};
            gen_started = 1'b1;
        end
        // below the limit the counter runs free; at or above it, only a newer clock rebases
        if (gen_tick < gen_limit) begin
            gen_tick = gen_tick + 1'b1;
        end else if ({4'b0, now} > gen_base + gen_tick) begin
            gen_tick = '0;
            gen_base = {4'b0, now};
        end else begin
            gen_tick = gen_tick + 1'b1;
        end
        stamp = gen_base + gen_tick;
        // reseed on first use or a node change, bump when time went backwards
        if (fresh || node != gen_last_node) begin
            gen_clkseq = seed;
        end else if (stamp < gen_last_stamp) begin
            gen_clkseq = gen_clkseq + 1'b1;
        end
        res.hi = {stamp[31:0], stamp[47:32], UUID_VERSION, stamp[59:48]};
        res.lo = {UUID_VARIANT, gen_clkseq[13:0], node};
        gen_last_stamp = stamp;
        gen_last_node  = node;
        return res;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int unsigned idle_length(input bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm) begin
            return 0;
        end else if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(4, 24);
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_request(input logic [TIME_W-1:0] sys_time,
                                 input logic [NODE_W-1:0] node,
                                 input logic [SEQ_W-1:0]  seed);
        t_uuid_req req;
        req          = '0;
        req.sys_time = sys_time;
        req.node     = node;
        req.seed     = seed;
        request_q.push_back(req);
    endtask

    // sender holds off until every queued beat is out and every identifier is back;
    // looked at mid-cycle, once the edge's updates have all landed
    task automatic drain_all();
        do begin
            @(negedge i_clk);
        end while (request_q.size() != 0 || i_in_valid || uuid_due_q.size() != 0);
    endtask

    // limit register is only written with the pipe empty
    task automatic load_limit(input logic [TICK_W-1:0] value);
        drain_all();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        gen_limit      = value;
    endtask

    task automatic flag_mismatch(input string field, input logic [HALF_W-1:0] want,
                                 input logic [HALF_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        in_stall_s  <= o_in_stall;
        out_valid_s <= o_out_valid;
        high_s      <= o_uuid_high;
        low_s       <= o_uuid_low;
    end

    // request side: a beat moves when valid is high and the sampled stall is low;
    // a stalled beat keeps its payload, otherwise an idle gap or the next request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_stall_s) begin
                predicted = stamp_uuid(cur_req.sys_time, cur_req.node, cur_req.seed);
                // hand-typed rows are checked against their own answer
                if (cur_req.typed) begin
                    uuid_due_q.push_back('{cur_req.hi, cur_req.lo});
                end else begin
                    uuid_due_q.push_back(predicted);
                end
            end
            if (!(i_in_valid && in_stall_s)) begin
                if (feed_gap != 0) begin
                    feed_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    cur_req        = request_q.pop_front();
                    i_system_time <= cur_req.sys_time;
                    i_node_id     <= cur_req.node;
                    i_random_seq  <= cur_req.seed;
                    i_in_valid    <= 1'b1;
                    // calm stretches give back-to-back beats
                    if (feed_calm != 0) begin
                        feed_calm--;
                    end else if ($urandom_range(0, 40) == 0) begin
                        feed_calm = $urandom_range(20, 80);
                    end
                    feed_gap = idle_length(feed_calm != 0);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side: check each accepted beat against the oldest expectation,
    // then pick the next stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid_s === 1'b1 && !i_out_stall) begin
                if (uuid_due_q.size() == 0) begin
                    $display("%0t: unexpected identifier, expected none, actual %h %h",
                             $time, high_s, low_s);
                    mismatches++;
                end else begin
                    expected = uuid_due_q.pop_front();
                    if (high_s !== expected.hi) begin
                        flag_mismatch("uuid_high", expected.hi, high_s);
                    end
                    if (low_s !== expected.lo) begin
                        flag_mismatch("uuid_low", expected.lo, low_s);
                    end
                end
            end
            if (hold_len != 0) begin
                hold_len--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (hold_calm != 0) begin
                    hold_calm--;
                end else if ($urandom_range(0, 40) == 0) begin
                    hold_calm = $urandom_range(20, 80);
                end
                hold_len = idle_length(hold_calm != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [TIME_W-1:0] clk_now;
        logic [NODE_W-1:0] cur_node;
        logic [63:0]       wide;
        logic [63:0]       noise;
        int unsigned       roll;
        int unsigned       row;
        int unsigned       phase;
        int unsigned       beat;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: requests go to the feeder, limit rows wait for an empty pipe
        for (row = 0; row < DIR_COUNT; row++) begin
            if (DIR_ROWS[row].kind == ROW_LIMIT) begin
                load_limit(DIR_ROWS[row].limit);
            end else begin
                request_q.push_back(DIR_ROWS[row].req);
            end
        end

        // random phases: a running clock with small steps, jumps and slips,
        // an occasional node change, and some fully random noise beats
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            load_limit(PHASE_LIMITS[phase]);
            if ($urandom_range(0, 2) == 0) begin
                clk_now = TIME_MAX - $urandom_range(0, 400);
            end else begin
                wide    = rand64();
                clk_now = wide[TIME_W-1:0];
            end
            wide     = rand64();
            cur_node = wide[NODE_W-1:0];
            for (beat = 0; beat < PHASE_BEATS; beat++) begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 24) == 0) begin
                    wide     = rand64();
                    cur_node = wide[NODE_W-1:0];
                end
                if (roll < 75) begin
                    clk_now = clk_now + $urandom_range(0, 4);
                end else if (roll < 85) begin
                    clk_now = clk_now + $urandom_range(5, 5000);
                end else if (roll < 93) begin
                    clk_now = clk_now - $urandom_range(1, 60);
                end
                if (roll < 93) begin
                    queue_request(clk_now, cur_node, SEQ_W'($urandom));
                end else begin
                    wide  = rand64();
                    noise = rand64();
                    queue_request(wide[TIME_W-1:0], noise[NODE_W-1:0], SEQ_W'($urandom));
                end
                // now and then let everything come back before going on
                if ($urandom_range(0, 59) == 0) begin
                    drain_all();
                end
            end
        end

        drain_all();
        // wait on to catch any stray identifier
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
